// File: rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// Gap buffer text store package
// Shared widths, operation codes and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned MAX_RUN_DEF  = 64;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned RLEN_W = 7;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_LEFT   = 3'd1;
  localparam logic [OP_W-1:0] OP_MOVE_LEFT  = 3'd2;
  localparam logic [OP_W-1:0] OP_MOVE_RIGHT = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_RUN   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  typedef struct packed {
    logic latch;
    logic set_full;
    logic do_insert;
    logic do_delete;
    logic do_clear;
    logic mv_read;
    logic mv_write;
    logic calc_run;
    logic issue;
    logic load_char;
    logic load_last;
    logic load_status;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            gap_full;
    logic            at_start;
    logic            at_end;
    logic            run_empty;
    logic            run_more;
    logic            run_next_last;
    logic            out_free;
  } stat_t;

endpackage

// File: rtl/gbts_ctrl.sv
// ----------------------------------------------------------------------------
// Gap buffer text store controller
// Sequences one item at a time: decode, optional move write, run reads and
// the status result of an edit or an empty run.
// ----------------------------------------------------------------------------
module gbts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  gbts_pkg::stat_t stat,
  output gbts_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE,
    S_CHECK,
    S_RUN,
    S_STATUS
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic   pend_last_r, pend_last_nxt;
  logic   load;
  logic   issue;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    load          = pend_r && stat.out_free;
    issue         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_STATUS;
        unique case (stat.op)
          gbts_pkg::OP_INSERT: begin
            if (stat.gap_full) cmd.set_full  = 1'b1;
            else               cmd.do_insert = 1'b1;
          end
          gbts_pkg::OP_DEL_LEFT: begin
            cmd.do_delete = !stat.at_start;
          end
          gbts_pkg::OP_MOVE_LEFT: begin
            if (!stat.at_start) begin
              cmd.mv_read = 1'b1;
              state_nxt   = S_MOVE;
            end
          end
          gbts_pkg::OP_MOVE_RIGHT: begin
            if (!stat.at_end) begin
              cmd.mv_read = 1'b1;
              state_nxt   = S_MOVE;
            end
          end
          gbts_pkg::OP_READ_RUN: begin
            cmd.calc_run = 1'b1;
            state_nxt    = S_CHECK;
          end
          gbts_pkg::OP_CLEAR: begin
            cmd.do_clear = 1'b1;
          end
          default: begin
            state_nxt = S_STATUS;
          end
        endcase
      end
      S_MOVE: begin
        cmd.mv_write = 1'b1;
        state_nxt    = S_STATUS;
      end
      S_CHECK: begin
        pend_nxt  = 1'b0;
        state_nxt = stat.run_empty ? S_STATUS : S_RUN;
      end
      S_RUN: begin
        // One read may be in flight in the registered store output; a new
        // read goes out only when that character leaves in the same cycle.
        issue         = stat.run_more && (!pend_r || load);
        cmd.issue     = issue;
        cmd.load_char = load;
        cmd.load_last = pend_last_r;
        if (issue) begin
          pend_nxt      = 1'b1;
          pend_last_nxt = stat.run_next_last;
        end else if (load) begin
          pend_nxt = 1'b0;
        end
        if (load && pend_last_r) state_nxt = S_IDLE;
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.load_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

endmodule

// File: rtl/gbts_dpath.sv
// ----------------------------------------------------------------------------
// Gap buffer text store datapath
// Holds the byte store, the gap pointers, the run counter and the output
// register; acts on commands from the controller.
// ----------------------------------------------------------------------------
module gbts_dpath #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEF,
  parameter int unsigned MAX_RUN  = gbts_pkg::MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gbts_pkg::cmd_t                cmd,
  output gbts_pkg::stat_t               stat,
  input  logic [gbts_pkg::OP_W-1:0]     in_operation,
  input  logic [gbts_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [gbts_pkg::POS_W-1:0]    in_start_index,
  input  logic [gbts_pkg::POS_W-1:0]    in_end_index,
  input  logic [gbts_pkg::RLEN_W-1:0]   in_run_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gbts_pkg::BYTE_W-1:0]   out_char,
  output logic                          out_char_valid,
  output logic                          out_last,
  output logic [gbts_pkg::POS_W-1:0]    out_cursor,
  output logic [gbts_pkg::POS_W-1:0]    out_text_length,
  output logic                          out_full
);

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = ((PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W) + 1;

  logic [gbts_pkg::OP_W-1:0]   op_r;
  logic [gbts_pkg::BYTE_W-1:0] byte_r;
  logic [gbts_pkg::POS_W-1:0]  start_r;
  logic [gbts_pkg::POS_W-1:0]  end_r;
  logic [gbts_pkg::RLEN_W-1:0] rlen_r;
  logic                        full_r;

  logic [PW-1:0] gs_r, ge_r, gap_len_r;
  logic [CW-1:0] li_r, stop_r;

  logic [gbts_pkg::BYTE_W-1:0] store_r [CAPACITY];
  logic [gbts_pkg::BYTE_W-1:0] rdata_r;

  logic                        out_valid_r;
  logic [gbts_pkg::BYTE_W-1:0] out_char_r;
  logic                        out_cv_r;
  logic                        out_last_r;
  logic [gbts_pkg::POS_W-1:0]  out_cursor_r;
  logic [gbts_pkg::POS_W-1:0]  out_len_r;
  logic                        out_full_r;

  logic [PW-1:0]               gap_len, tlen, gs_dec, ge_dec;
  logic [gbts_pkg::RLEN_W-1:0] run_n;
  logic [CW-1:0]               stop_sum, stop_a, stop_b, phys;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [gbts_pkg::BYTE_W-1:0] wr_data;
  logic                        is_left;

  assign gap_len = ge_r - gs_r;
  assign tlen    = PW'(CAPACITY) - gap_len;
  assign gs_dec  = gs_r - PW'(1);
  assign ge_dec  = ge_r - PW'(1);
  assign is_left = (op_r == gbts_pkg::OP_MOVE_LEFT);

  // Clip the run to MAX_RUN, then to the end index, then to the text.
  assign run_n    = (rlen_r > gbts_pkg::RLEN_W'(MAX_RUN)) ?
                    gbts_pkg::RLEN_W'(MAX_RUN) : rlen_r;
  assign stop_sum = CW'(start_r) + CW'(run_n);
  assign stop_a   = (stop_sum > CW'(end_r)) ? CW'(end_r) : stop_sum;
  assign stop_b   = (stop_a > CW'(tlen)) ? CW'(tlen) : stop_a;

  // Logical index to store address: indexes at or past the cursor skip the gap.
  assign phys = (li_r < CW'(gs_r)) ? li_r : li_r + CW'(gap_len_r);

  assign wr_en   = cmd.do_insert || cmd.mv_write;
  assign wr_addr = (cmd.mv_write && is_left) ? ge_dec[AW-1:0] : gs_r[AW-1:0];
  assign wr_data = cmd.mv_write ? rdata_r : byte_r;
  assign rd_en   = cmd.mv_read || cmd.issue;
  assign rd_addr = cmd.issue ? phys[AW-1:0] :
                   (is_left ? gs_dec[AW-1:0] : ge_r[AW-1:0]);

  always_ff @(posedge clk) begin
    if (wr_en) store_r[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= store_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_operation;
      byte_r  <= in_data_byte;
      start_r <= in_start_index;
      end_r   <= in_end_index;
      rlen_r  <= in_run_length;
    end
    if (cmd.calc_run) begin
      stop_r    <= stop_b;
      li_r      <= CW'(start_r);
      gap_len_r <= gap_len;
    end else if (cmd.issue) begin
      li_r <= li_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r   <= '0;
      ge_r   <= PW'(CAPACITY);
      full_r <= 1'b0;
    end else begin
      if (cmd.latch)         full_r <= 1'b0;
      else if (cmd.set_full) full_r <= 1'b1;
      if (cmd.do_clear) begin
        gs_r <= '0;
        ge_r <= PW'(CAPACITY);
      end else if (cmd.do_insert) begin
        gs_r <= gs_r + PW'(1);
      end else if (cmd.do_delete) begin
        gs_r <= gs_dec;
      end else if (cmd.mv_write) begin
        if (is_left) begin
          gs_r <= gs_dec;
          ge_r <= ge_dec;
        end else begin
          gs_r <= gs_r + PW'(1);
          ge_r <= ge_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_char || cmd.load_status) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char || cmd.load_status) begin
      out_char_r   <= cmd.load_char ? rdata_r : '0;
      out_cv_r     <= cmd.load_char;
      out_last_r   <= cmd.load_char ? cmd.load_last : 1'b1;
      out_full_r   <= cmd.load_status && full_r;
      out_cursor_r <= gbts_pkg::POS_W'(gs_r);
      out_len_r    <= gbts_pkg::POS_W'(tlen);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_char_valid  = out_cv_r;
  assign out_last        = out_last_r;
  assign out_cursor      = out_cursor_r;
  assign out_text_length = out_len_r;
  assign out_full        = out_full_r;

  always_comb begin
    stat               = '0;
    stat.op            = op_r;
    stat.gap_full      = (gs_r == ge_r);
    stat.at_start      = (gs_r == '0);
    stat.at_end        = (ge_r == PW'(CAPACITY));
    stat.run_empty     = (li_r >= stop_r);
    stat.run_more      = (li_r < stop_r);
    stat.run_next_last = ((li_r + CW'(1)) == stop_r);
    stat.out_free      = !out_valid_r || out_ready;
  end

endmodule

// File: rtl/gap_buffer_text_store_core.sv
// ----------------------------------------------------------------------------
// Gap buffer text store core
// Byte text store with the cursor at the gap; edit and read-run operations.
// ----------------------------------------------------------------------------
// Usage: each item on the in_ channel carries an operation in in_tuser and
// its operands in in_tdata. Edits (insert, delete left, move left and right,
// clear) give one status item; a read run gives one item per character,
// with out_tlast on the final one, or a single empty status item.
// Every result item reports the cursor and the text length.
// The block works on one item at a time: in_tready is high only when the
// previous item has been fully handed to the output register.
// Sequence: insert, delete, clear and unused codes pass the decode and status
// states from accept to result and to the next accept; a move adds a move
// state, since it reads and then writes the single-port byte store. A read
// run passes the decode and check states, then streams one character per
// cycle through the registered store read port while out_tready stays high.
// When the receiver stalls, the result waits in the output register and the
// run pauses with at most one character held in the store read register.
// Reset empties the text and puts the cursor at zero; the store contents
// are not cleared.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_core #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEF,
  parameter int unsigned MAX_RUN  = gbts_pkg::MAX_RUN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] data_byte, [18:8] start_index, [29:19] end_index,
  // [36:30] run_length, [39:37] zero
  input  logic [gbts_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] operation
  input  logic [gbts_pkg::OP_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] char_out, [18:8] cursor_pos, [29:19] text_length,
  // [30] full_flag, [31] zero
  output logic [gbts_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] char_valid
  output logic [0:0]                         out_tuser,
  output logic                               out_tlast
);

  gbts_pkg::cmd_t  cmd;
  gbts_pkg::stat_t stat;

  logic [gbts_pkg::BYTE_W-1:0] out_char;
  logic                        out_char_valid;
  logic [gbts_pkg::POS_W-1:0]  out_cursor;
  logic [gbts_pkg::POS_W-1:0]  out_text_length;
  logic                        out_full;

  gbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbts_dpath #(
    .CAPACITY (CAPACITY),
    .MAX_RUN  (MAX_RUN)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_tuser),
    .in_data_byte    (in_tdata[7:0]),
    .in_start_index  (in_tdata[18:8]),
    .in_end_index    (in_tdata[29:19]),
    .in_run_length   (in_tdata[36:30]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_char        (out_char),
    .out_char_valid  (out_char_valid),
    .out_last        (out_tlast),
    .out_cursor      (out_cursor),
    .out_text_length (out_text_length),
    .out_full        (out_full)
  );

  assign out_tdata = {1'b0, out_full, out_text_length, out_cursor, out_char};
  assign out_tuser = out_char_valid;

  // The byte store has one port: at most one access in any cycle.
  a_store_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.do_insert, cmd.mv_read, cmd.mv_write, cmd.issue}) <= 1)
    else $error("byte store accessed twice in one cycle");

  // One item at a time: an accepted item closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // A character result never reports a dropped insert.
  a_char_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tdata[30])
    else $error("full flag on a character result");

  // A status result is always the final result of its item.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("status result without last");

endmodule

// File: verif/gap_buffer_text_store_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gap buffer text store core testbench
// Drives edits and read runs on the in_ stream and checks every out_ item.
// A scoreboard keeps its own copy of the text and gap to predict results.
// Both stream sides idle at random, and the receiver stalls once for a long
// stretch so that the core backs up.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_core_tb;

  localparam int unsigned CAP         = gbts_pkg::CAPACITY_DEF;
  localparam int unsigned RUN_LIMIT   = gbts_pkg::MAX_RUN_DEF;
  localparam int unsigned HOLD_CYCLES = 200;

  // Codes the core has no use for; they only give a status item.
  localparam logic [gbts_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [gbts_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [7:0]  ch;
    logic        ch_valid;
    logic        last;
    logic [10:0] cursor;
    logic [10:0] length;
    logic        full;
  } text_result_t;

  class gap_text_scoreboard;
    logic [7:0]   text_mem [CAP];
    int unsigned  gap_lo;
    int unsigned  gap_hi;
    text_result_t awaited[$];
    int unsigned  errors;

    function new();
      gap_lo = 0;
      gap_hi = CAP;
      errors = 0;
    endfunction

    function int unsigned text_len();
      return CAP - (gap_hi - gap_lo);
    endfunction

    function void push_result(logic [7:0] ch, logic ch_valid, logic last, logic full);
      text_result_t r;
      r.ch       = ch;
      r.ch_valid = ch_valid;
      r.last     = last;
      r.cursor   = gap_lo[10:0];
      r.length   = 11'(text_len());
      r.full     = full;
      awaited.push_back(r);
    endfunction

    function void note_input(logic [gbts_pkg::OP_W-1:0] op, logic [7:0] data_byte,
                             logic [10:0] start_idx, logic [10:0] stop_idx,
                             logic [6:0] run_len);
      int unsigned n, stop, cnt, li, p;
      logic full;
      full = 1'b0;
      case (op)
        gbts_pkg::OP_INSERT: begin
          if (gap_lo == gap_hi) begin
            full = 1'b1;
          end else begin
            text_mem[gap_lo] = data_byte;
            gap_lo++;
          end
        end
        gbts_pkg::OP_DEL_LEFT: begin
          if (gap_lo > 0) gap_lo--;
        end
        gbts_pkg::OP_MOVE_LEFT: begin
          if (gap_lo > 0) begin
            gap_lo--;
            gap_hi--;
            text_mem[gap_hi] = text_mem[gap_lo];
          end
        end
        gbts_pkg::OP_MOVE_RIGHT: begin
          if (gap_hi < CAP) begin
            text_mem[gap_lo] = text_mem[gap_hi];
            gap_lo++;
            gap_hi++;
          end
        end
        gbts_pkg::OP_READ_RUN: begin
          n    = (run_len > RUN_LIMIT) ? RUN_LIMIT : run_len;
          stop = start_idx + n;
          if (stop > stop_idx) stop = stop_idx;
          if (stop > text_len()) stop = text_len();
          cnt = (stop > start_idx) ? stop - start_idx : 0;
          if (cnt != 0) begin
            for (int unsigned i = 0; i < cnt; i++) begin
              li = start_idx + i;
              p  = (li < gap_lo) ? li : li + (gap_hi - gap_lo);
              push_result(text_mem[p], 1'b1, (i + 1 == cnt), 1'b0);
            end
            return;
          end
        end
        gbts_pkg::OP_CLEAR: begin
          gap_lo = 0;
          gap_hi = CAP;
        end
        default: ;
      endcase
      push_result(8'd0, 1'b0, 1'b1, full);
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [gbts_pkg::OUT_TDATA_W-1:0] tdata, logic ch_valid,
                               logic last);
      text_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result item with nothing expected: tdata %h, valid %b, last %b",
                 $time, tdata, ch_valid, last);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("char_out", 32'(want.ch), 32'(tdata[7:0]));
      compare_field("char_valid", 32'(want.ch_valid), 32'(ch_valid));
      compare_field("last", 32'(want.last), 32'(last));
      compare_field("cursor_pos", 32'(want.cursor), 32'(tdata[18:8]));
      compare_field("text_length", 32'(want.length), 32'(tdata[29:19]));
      compare_field("full_flag", 32'(want.full), 32'(tdata[30]));
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // [7:0] data_byte, [18:8] start_index, [29:19] end_index,
  // [36:30] run_length, [39:37] zero
  logic [gbts_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  // [2:0] operation
  logic [gbts_pkg::OP_W-1:0]        in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // [7:0] char_out, [18:8] cursor_pos, [29:19] text_length,
  // [30] full_flag, [31] zero
  logic [gbts_pkg::OUT_TDATA_W-1:0] out_tdata;
  // [0] char_valid
  logic [0:0]                       out_tuser;
  logic                             out_tlast;

  gap_text_scoreboard sb;
  int unsigned        items_sent = 0;
  bit                 quiet = 1'b0;
  bit                 hold_request = 1'b0;

  gap_buffer_text_store_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_input(in_tuser, in_tdata[7:0], in_tdata[18:8], in_tdata[29:19],
                      in_tdata[36:30]);
      end
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0], out_tlast);
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic send_item(input logic [gbts_pkg::OP_W-1:0] op, input logic [7:0] data_byte,
                           input logic [10:0] start_idx, input logic [10:0] stop_idx,
                           input logic [6:0] run_len);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, run_len, stop_idx, start_idx, data_byte};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Edits ignore the read fields, so those carry random values.
  task automatic send_op(input logic [gbts_pkg::OP_W-1:0] op, input logic [7:0] data_byte);
    send_item(op, data_byte, 11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024)),
              7'($urandom_range(0, 127)));
  endtask

  task automatic directed_checks();
    send_item(gbts_pkg::OP_READ_RUN, 8'h00, 11'd0, 11'd0, 7'd1);
    send_op(gbts_pkg::OP_DEL_LEFT, 8'h00);
    send_op(gbts_pkg::OP_MOVE_LEFT, 8'h00);
    send_op(gbts_pkg::OP_MOVE_RIGHT, 8'h00);
    send_op(OP_SPARE_6, 8'h00);
    send_op(OP_SPARE_7, 8'hFF);
    send_op(gbts_pkg::OP_INSERT, 8'h00);
    send_op(gbts_pkg::OP_INSERT, 8'hFF);
    send_op(gbts_pkg::OP_INSERT, 8'hA5);
    send_op(gbts_pkg::OP_INSERT, 8'h5A);
    send_op(gbts_pkg::OP_INSERT, 8'h41);
    send_op(gbts_pkg::OP_MOVE_LEFT, 8'h00);
    send_op(gbts_pkg::OP_MOVE_LEFT, 8'h00);
    // The whole text, read across the gap.
    send_item(gbts_pkg::OP_READ_RUN, 8'h00, 11'd0, 11'd1024, 7'd64);
    send_item(gbts_pkg::OP_READ_RUN, 8'h00, 11'd0, 11'd1024, 7'd0);
    send_item(gbts_pkg::OP_READ_RUN, 8'h00, 11'd1, 11'd3, 7'd127);
    send_item(gbts_pkg::OP_READ_RUN, 8'h00, 11'd1024, 11'd1024, 7'd64);
    send_op(gbts_pkg::OP_MOVE_RIGHT, 8'h00);
    send_op(gbts_pkg::OP_MOVE_RIGHT, 8'h00);
    send_op(gbts_pkg::OP_MOVE_RIGHT, 8'h00);
    send_op(gbts_pkg::OP_DEL_LEFT, 8'h00);
    send_item(gbts_pkg::OP_READ_RUN, 8'h00, 11'd3, 11'd2, 7'd5);
    send_op(gbts_pkg::OP_CLEAR, 8'h00);
    send_item(gbts_pkg::OP_READ_RUN, 8'h00, 11'd0, 11'd10, 7'd10);
  endtask

  task automatic random_phase(input int unsigned n_items, input int unsigned quiet_from);
    int unsigned base, pick, cnt, len, s, e, r;
    base = items_sent;
    while (items_sent - base < n_items) begin
      if (items_sent - base >= quiet_from) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      len  = sb.text_len();
      if (pick < 35) begin
        cnt = $urandom_range(1, 8);
        repeat (cnt) send_op(gbts_pkg::OP_INSERT, 8'($urandom_range(0, 255)));
      end else if (pick < 50) begin
        cnt = $urandom_range(1, 6);
        repeat (cnt) send_op($urandom_range(0, 1) ? gbts_pkg::OP_MOVE_LEFT :
                             gbts_pkg::OP_MOVE_RIGHT, 8'h00);
      end else if (pick < 75) begin
        s = $urandom_range(0, len + 2);
        if (s > 1024) s = 1024;
        e = s + $urandom_range(0, 80);
        if ($urandom_range(0, 7) == 0) e = $urandom_range(0, 1024);
        if (e > 1024) e = 1024;
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        send_item(gbts_pkg::OP_READ_RUN, 8'($urandom_range(0, 255)), 11'(s), 11'(e), 7'(r));
      end else if (pick < 85) begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) send_op(gbts_pkg::OP_DEL_LEFT, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        // A fresh string: clear, then one insert per byte.
        send_op(gbts_pkg::OP_CLEAR, 8'h00);
        cnt = $urandom_range(5, 40);
        repeat (cnt) send_op(gbts_pkg::OP_INSERT, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        if ($urandom_range(0, 1)) begin
          send_op($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, 8'($urandom_range(0, 255)));
        end else begin
          send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024)),
                    7'($urandom_range(0, 127)));
        end
      end else begin
        // A longer random walk of the cursor that can reach an edge and push past it.
        cnt = $urandom_range(1, 20);
        repeat (cnt) send_op($urandom_range(0, 1) ? gbts_pkg::OP_MOVE_LEFT :
                             gbts_pkg::OP_MOVE_RIGHT, 8'h00);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    // The receiver holds off while the sender keeps offering items.
    hold_request = 1'b1;
    random_phase(180, 180);
    random_phase(200, 140);
    in_tvalid <= 1'b0;
    // Let the monitor take in the last accepted item before waiting on it.
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
